[rtl/core/tzsm_pkg.sv]
package tzsm_pkg;

  localparam logic [2:0] CMD_RESET    = 3'd0;
  localparam logic [2:0] CMD_ZOOM_IN  = 3'd1;
  localparam logic [2:0] CMD_ZOOM_OUT = 3'd2;
  localparam logic [2:0] CMD_SET_ZOOM = 3'd3;
  localparam logic [2:0] CMD_TO_PIXEL = 3'd4;
  localparam logic [2:0] CMD_TO_SAMPLE = 3'd5;
  localparam logic [2:0] CMD_TICK     = 3'd6;

  localparam logic [1:0] REG_SCREEN_WIDTH = 2'd0;
  localparam logic [1:0] REG_CENTER_ALIGN = 2'd1;
  localparam logic [1:0] REG_REF_SAMPLE   = 2'd2;
  localparam logic [1:0] REG_MIN_TICK_GAP = 2'd3;

  localparam logic [29:0] MAX_ZOOM = 30'd1000000000;

  localparam int DIV_STEPS = 33;
  localparam int MUL_STEPS = 30;

  // Largest power of ten at or below the limit; cap_fac then picks 1, 2 or 5 times it.
  function automatic logic [33:0] cap_power(input logic [29:0] lim);
    logic [33:0] p;
    p = 34'd1;
    for (int i = 0; i < 10; i++) begin
      if ({4'd0, lim} >= p * 34'd10) p = p * 34'd10;
    end
    return p;
  endfunction

  function automatic logic [2:0] cap_fac(input logic [29:0] lim);
    logic [33:0] p;
    p = cap_power(lim);
    if (p * 34'd5 <= {4'd0, lim}) return 3'd5;
    else if (p * 34'd2 <= {4'd0, lim}) return 3'd2;
    else return 3'd1;
  endfunction

  localparam logic [2:0]  CAP_FAC = cap_fac(MAX_ZOOM);
  localparam logic [33:0] CAP_WIDE = cap_power(MAX_ZOOM) * 34'(CAP_FAC);
  localparam logic [29:0] CAP_VALUE = CAP_WIDE[29:0];

  typedef struct packed {
    logic load;
    logic mul_start;
    logic div_start;
    logic lad_start;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_mul;
    logic need_div;
    logic need_lad;
    logic mul_done;
    logic div_done;
    logic lad_done;
  } dp_stat_t;

endpackage

[rtl/core/tzsm_ctrl.sv]
module tzsm_ctrl
  import tzsm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_stat_t   stat,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_MUL, S_DIV, S_LAD, S_FINISH, S_HOLD
  } state_t;

  state_t state;
  logic   mul_start, div_start, lad_start, finish;

  assign in_stall = (state != S_IDLE);
  assign cmd.load = in_valid && (state == S_IDLE);
  assign cmd.mul_start = mul_start;
  assign cmd.div_start = div_start;
  assign cmd.lad_start = lad_start;
  assign cmd.finish = finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mul_start <= 1'b0;
      div_start <= 1'b0;
      lad_start <= 1'b0;
      finish <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
      lad_start <= 1'b0;
      finish <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_DISPATCH;
        end
        S_DISPATCH: begin
          if (stat.need_mul) begin
            mul_start <= 1'b1;
            state <= S_MUL;
          end else if (stat.need_div) begin
            div_start <= 1'b1;
            state <= S_DIV;
          end else if (stat.need_lad) begin
            lad_start <= 1'b1;
            state <= S_LAD;
          end else begin
            finish <= 1'b1;
            state <= S_FINISH;
          end
        end
        S_MUL, S_DIV: begin
          if ((state == S_MUL && stat.mul_done) || (state == S_DIV && stat.div_done)) begin
            if (stat.need_lad) begin
              lad_start <= 1'b1;
              state <= S_LAD;
            end else begin
              finish <= 1'b1;
              state <= S_FINISH;
            end
          end
        end
        S_LAD: begin
          if (stat.lad_done) begin
            finish <= 1'b1;
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          out_valid <= 1'b1;
          state <= S_HOLD;
        end
        S_HOLD: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/tzsm_dp.sv]
module tzsm_dp
  import tzsm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  ctrl_cmd_t          cmd,
  output dp_stat_t           stat,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic [2:0]         command,
  input  logic signed [30:0] zoom_value,
  input  logic signed [31:0] sample_index,
  input  logic signed [16:0] pixel_coord,
  output logic signed [31:0] mapped_position,
  output logic [29:0]        zoom_magnitude,
  output logic               zoom_below_one,
  output logic [1:0]         ladder_index,
  output logic [42:0]        tick_spacing,
  output logic [2:0]         tick_factor,
  output logic [3:0]         tick_power
);

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  logic [12:0]        screen_width;
  logic               center_align;
  logic signed [31:0] reference_sample;
  logic [9:0]         min_tick_gap;
  logic [29:0]        zoom_mag;
  logic               below_one;
  logic [1:0]         step_index;

  logic [2:0]         cmd_q;
  logic signed [30:0] zval_q;
  logic signed [31:0] samp_q;
  logic signed [16:0] pix_q;

  // Shared divider, multiplier and decade search.
  logic        div_busy;
  logic [5:0]  div_cnt;
  logic [32:0] div_dq;
  logic [29:0] div_rem;
  logic [29:0] div_dvs;
  logic        mul_busy;
  logic [4:0]  mul_cnt;
  logic [62:0] mul_a;
  logic [29:0] mul_b;
  logic [62:0] mul_acc;
  logic        lad_busy;
  logic [39:0] lad_t;
  logic [43:0] lad_p;
  logic [3:0]  lad_n;
  logic [42:0] lad_res;
  logic [2:0]  lad_fac;
  logic [3:0]  lad_pow;

  logic signed [14:0] base;
  logic [29:0]        mag_e;
  logic signed [32:0] d;
  logic               dneg;
  logic [32:0]        dabs;
  logic signed [17:0] dx;
  logic               dxneg;
  logic [17:0]        dxabs;
  logic signed [30:0] zs;
  logic               zpos;
  logic [30:0]        zabs;
  logic               b_in;
  logic [1:0]         idx_in, idx_out, idx_out_next, idx_z;
  logic               mult5, div_branch;
  logic [61:0]        fifth_prod;
  logic [32:0]        m;
  logic               zoom_ok;

  logic [30:0] div_trial;
  logic        div_ge;
  logic [30:0] div_diff;
  logic [43:0] p10, p5, t44;
  logic [32:0] dividend;
  logic [32:0] multiplicand;
  logic [39:0] ceil_q;

  logic signed [63:0] prod64, quo64, sprod, squo, base64, ref64;
  logic               map_neg;
  logic [29:0]        set_mag;
  logic [2:0]         set_fac;

  assign cfg_ready = 1'b1;

  assign base = center_align ? $signed({3'd0, screen_width[12:1]})
                             : $signed({2'd0, screen_width}) - 15'sd1;
  assign mag_e = (zoom_mag == 30'd0) ? 30'd1 : zoom_mag;
  assign d = {reference_sample[31], reference_sample} - {samp_q[31], samp_q};
  assign dneg = d[32];
  assign dabs = dneg ? 33'(-d) : 33'(d);
  assign dx = {pix_q[16], pix_q} - {{3{base[14]}}, base};
  assign dxneg = dx[17];
  assign dxabs = dxneg ? 18'(-dx) : 18'(dx);
  assign zs = (zval_q == 31'sd0 || zval_q == 31'sd1) ? -31'sd1 : zval_q;
  assign zpos = !zs[30];
  assign zabs = zpos ? 31'(zs) : 31'(-zs);

  // Zoom stepping on the 1-2-5 ladder.
  assign b_in = below_one || (zoom_mag == 30'd1);
  always_comb begin
    case (step_index)
      2'd0: idx_in = 2'd2;
      2'd1: idx_in = 2'd0;
      2'd2: idx_in = 2'd1;
      default: idx_in = 2'd2;
    endcase
    idx_out = (step_index == 2'd3) ? 2'd0 : step_index;
    case (idx_out)
      2'd0: idx_out_next = 2'd1;
      2'd1: idx_out_next = 2'd2;
      default: idx_out_next = 2'd0;
    endcase
  end
  assign idx_z = (cmd_q == CMD_ZOOM_IN) ? idx_in : idx_out;
  assign mult5 = (idx_z == 2'd1);
  assign div_branch = (cmd_q == CMD_ZOOM_IN) ? !b_in : below_one;

  // Twice the magnitude divided by five as a reciprocal multiply; exact for
  // any operand below 2^31.
  assign fifth_prod = {31'd0, zoom_mag, 1'b0} * 62'd1717986919;

  always_comb begin
    if (!div_branch) begin
      if (mult5) m = ({3'd0, zoom_mag} + {1'b0, zoom_mag, 2'b00}) >> 1;
      else m = {2'd0, zoom_mag, 1'b0};
    end else begin
      if (mult5) m = {4'd0, fifth_prod[61:33]};
      else m = {4'd0, zoom_mag[29:1]};
    end
  end
  assign zoom_ok = (m <= {3'd0, MAX_ZOOM});

  always_comb begin
    stat.need_mul = (cmd_q == CMD_TO_PIXEL && below_one)
                    || (cmd_q == CMD_TO_SAMPLE && !below_one)
                    || (cmd_q == CMD_TICK && !below_one);
    stat.need_div = (cmd_q == CMD_TO_PIXEL && !below_one)
                    || (cmd_q == CMD_TO_SAMPLE && below_one)
                    || (cmd_q == CMD_TICK && below_one);
    stat.need_lad = (cmd_q == CMD_SET_ZOOM) || (cmd_q == CMD_TICK);
    stat.mul_done = mul_busy && (mul_cnt == 5'(MUL_STEPS - 1));
    stat.div_done = div_busy && (div_cnt == 6'(DIV_STEPS - 1));
    stat.lad_done = lad_busy && (t44 < p10);
  end

  always_comb begin
    case (cmd_q)
      CMD_TO_PIXEL: begin
        dividend = dabs;
        multiplicand = dabs;
      end
      CMD_TO_SAMPLE: begin
        dividend = {15'd0, dxabs};
        multiplicand = {15'd0, dxabs};
      end
      CMD_TICK: begin
        dividend = {23'd0, min_tick_gap};
        multiplicand = {23'd0, min_tick_gap};
      end
      default: begin
        dividend = {2'd0, zoom_mag, 1'b0};
        multiplicand = {2'd0, zoom_mag, 1'b0};
      end
    endcase
  end

  assign div_trial = {div_rem, div_dq[32]};
  assign div_ge = (div_trial >= {1'b0, div_dvs});
  assign div_diff = div_trial - {1'b0, div_dvs};

  assign p10 = {lad_p[40:0], 3'b000} + {lad_p[42:0], 1'b0};
  assign p5 = {lad_p[41:0], 2'b00} + lad_p;
  assign t44 = {4'd0, lad_t};
  assign ceil_q = {7'd0, div_dq} + {39'd0, (div_rem != 30'd0)};

  assign map_neg = (cmd_q == CMD_TO_PIXEL) ? dneg : dxneg;
  assign prod64 = {1'b0, mul_acc};
  assign quo64 = {31'd0, div_dq};
  assign sprod = map_neg ? -prod64 : prod64;
  assign squo = map_neg ? -quo64 : quo64;
  assign base64 = {{49{base[14]}}, base};
  assign ref64 = {{32{reference_sample[31]}}, reference_sample};

  always_comb begin
    if (lad_res > {13'd0, MAX_ZOOM}) begin
      set_mag = CAP_VALUE;
      set_fac = CAP_FAC;
    end else begin
      set_mag = lad_res[29:0];
      set_fac = lad_fac;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width <= 13'd640;
      center_align <= 1'b0;
      reference_sample <= 32'sd0;
      min_tick_gap <= 10'd32;
      zoom_mag <= 30'd1;
      below_one <= 1'b0;
      step_index <= 2'd0;
      div_busy <= 1'b0;
      mul_busy <= 1'b0;
      lad_busy <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_SCREEN_WIDTH: screen_width <= cfg_data[12:0];
          REG_CENTER_ALIGN: center_align <= cfg_data[0];
          REG_REF_SAMPLE:   reference_sample <= $signed(cfg_data);
          REG_MIN_TICK_GAP: min_tick_gap <= cfg_data[9:0];
          default: ;
        endcase
      end

      if (cmd.div_start) begin
        div_busy <= 1'b1;
        div_cnt <= 6'd0;
        div_dq <= dividend;
        div_rem <= 30'd0;
        div_dvs <= mag_e;
      end else if (div_busy) begin
        div_rem <= div_ge ? div_diff[29:0] : div_trial[29:0];
        div_dq <= {div_dq[31:0], div_ge};
        div_cnt <= div_cnt + 6'd1;
        if (stat.div_done) div_busy <= 1'b0;
      end

      if (cmd.mul_start) begin
        mul_busy <= 1'b1;
        mul_cnt <= 5'd0;
        mul_a <= {30'd0, multiplicand};
        mul_b <= mag_e;
        mul_acc <= 63'd0;
      end else if (mul_busy) begin
        if (mul_b[0]) mul_acc <= mul_acc + mul_a;
        mul_a <= {mul_a[61:0], 1'b0};
        mul_b <= {1'b0, mul_b[29:1]};
        mul_cnt <= mul_cnt + 5'd1;
        if (stat.mul_done) mul_busy <= 1'b0;
      end

      if (cmd.lad_start) begin
        lad_busy <= 1'b1;
        lad_p <= 44'd1;
        lad_n <= 4'd0;
        if (cmd_q == CMD_SET_ZOOM) lad_t <= {9'd0, zabs};
        else if (below_one) lad_t <= ceil_q;
        else lad_t <= mul_acc[39:0];
      end else if (lad_busy) begin
        if (!stat.lad_done) begin
          lad_p <= p10;
          lad_n <= lad_n + 4'd1;
        end else begin
          lad_busy <= 1'b0;
          if (lad_p >= t44) begin
            lad_fac <= 3'd1;
            lad_res <= lad_p[42:0];
            lad_pow <= lad_n;
          end else if ({lad_p[42:0], 1'b0} >= t44) begin
            lad_fac <= 3'd2;
            lad_res <= {lad_p[41:0], 1'b0};
            lad_pow <= lad_n;
          end else if (p5 >= t44) begin
            lad_fac <= 3'd5;
            lad_res <= p5[42:0];
            lad_pow <= lad_n;
          end else begin
            lad_fac <= 3'd1;
            lad_res <= p10[42:0];
            lad_pow <= lad_n + 4'd1;
          end
        end
      end

      if (cmd.finish) begin
        case (cmd_q)
          CMD_RESET: begin
            zoom_mag <= 30'd1;
            below_one <= 1'b0;
            step_index <= 2'd0;
          end
          CMD_ZOOM_IN: begin
            if (zoom_ok) begin
              below_one <= b_in;
              step_index <= idx_in;
              zoom_mag <= m[29:0];
            end
          end
          CMD_ZOOM_OUT: begin
            if (zoom_ok) begin
              zoom_mag <= m[29:0];
              step_index <= idx_out_next;
              if (m == 33'd1) below_one <= 1'b0;
            end
          end
          CMD_SET_ZOOM: begin
            zoom_mag <= set_mag;
            below_one <= zpos;
            if (set_fac == 3'd1) step_index <= 2'd0;
            else if (set_fac == 3'd2) step_index <= zpos ? 2'd2 : 2'd1;
            else step_index <= zpos ? 2'd1 : 2'd2;
          end
          default: ;
        endcase
      end
    end
  end

  // Result fields; control in the sequencer keeps them held while offered.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q <= command;
      zval_q <= zoom_value;
      samp_q <= sample_index;
      pix_q <= pixel_coord;
    end
    if (cmd.finish) begin
      mapped_position <= 32'sd0;
      tick_spacing <= 43'd0;
      tick_factor <= 3'd0;
      tick_power <= 4'd0;
      case (cmd_q)
        CMD_TO_PIXEL:
          mapped_position <= sat32(base64 - (below_one ? sprod : squo));
        CMD_TO_SAMPLE:
          mapped_position <= sat32((below_one ? squo : sprod) + ref64);
        CMD_TICK: begin
          tick_spacing <= lad_res;
          tick_factor <= lad_fac;
          tick_power <= lad_pow;
        end
        default: ;
      endcase
    end
  end

  assign zoom_magnitude = zoom_mag;
  assign zoom_below_one = below_one;
  assign ladder_index = step_index;

endmodule

[rtl/core/timebase_zoom_and_sample_mapping.sv]
// Channel   Handshake                Payload
// request   in_valid / in_stall      command, zoom_value, sample_index, pixel_coord
// result    out_valid / out_stall    mapped_position, zoom_*, ladder_index, tick_*
// config    cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One request is handled at a time. Zoom-step and reset commands go straight
// to the result, setting the zoom runs the decade search, mappings run the
// serial multiplier or the serial divider, and tick spacing adds a decade
// search after that.
// Reset (rst, synchronous) restores the configuration defaults and unit zoom.
// While a result is offered and stalled, no new request is taken.
module timebase_zoom_and_sample_mapping
  import tzsm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         command,
  input  logic signed [30:0] zoom_value,
  input  logic signed [31:0] sample_index,
  input  logic signed [16:0] pixel_coord,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] mapped_position,
  output logic [29:0]        zoom_magnitude,
  output logic               zoom_below_one,
  output logic [1:0]         ladder_index,
  output logic [42:0]        tick_spacing,
  output logic [2:0]         tick_factor,
  output logic [3:0]         tick_power,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  // The sequencer steps each request through the shared arithmetic units.
  tzsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (dp_stat),
    .cmd       (ctrl_cmd)
  );

  // The datapath holds configuration, zoom state, the units and the result.
  tzsm_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (ctrl_cmd),
    .stat            (dp_stat),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .command         (command),
    .zoom_value      (zoom_value),
    .sample_index    (sample_index),
    .pixel_coord     (pixel_coord),
    .mapped_position (mapped_position),
    .zoom_magnitude  (zoom_magnitude),
    .zoom_below_one  (zoom_below_one),
    .ladder_index    (ladder_index),
    .tick_spacing    (tick_spacing),
    .tick_factor     (tick_factor),
    .tick_power      (tick_power)
  );

endmodule
